/* src/ramped_setpoint_p_controller_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the ramped setpoint controller
// Shared immediate-implication and next-cycle-implication checks.
// ---------------------------------------------------------------------------
`ifndef RAMPED_SETPOINT_P_CONTROLLER_UNIT_ASSERT_SVH
`define RAMPED_SETPOINT_P_CONTROLLER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define RSPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define RSPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rspc_pkg.sv */
// ---------------------------------------------------------------------------
// rspc_pkg
// Types, constants and reset values shared by the ramped setpoint controller.
// ---------------------------------------------------------------------------
package rspc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_WAYPOINT_PERIOD = 2'd0,
    CFG_SETPOINT_PERIOD = 2'd1,
    CFG_DRIVE_GAIN      = 2'd2,
    CFG_STEP_ANGLE      = 2'd3
  } cfg_index_t;

  localparam int CFG_DATA_W = 18;

  // Register reset values
  localparam logic [15:0] WAYPOINT_PERIOD_RST = 16'd4000;
  localparam logic [7:0]  SETPOINT_PERIOD_RST = 8'd100;
  localparam logic [17:0] DRIVE_GAIN_RST      = 18'd15360;
  localparam logic [14:0] STEP_ANGLE_RST      = 15'd3217;

  // Arithmetic layout
  localparam int          ACC_EXTRA  = 8;
  localparam int          GAIN_SHIFT = 20;
  localparam logic [7:0]  MAX_STEPS  = 8'd255;

  // Shared divider: 24-bit dividend, 8-bit divisor
  localparam int DIV_W     = 24;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  typedef enum logic {
    DIV_COUNT = 1'b0,
    DIV_DELTA = 1'b1
  } div_sel_t;

  // Input beat
  typedef struct packed {
    logic               sample_valid;
    logic signed [15:0] sample_theta;
    logic signed [31:0] sample_length;
  } sample_t;

  // Result beat
  typedef struct packed {
    logic signed [31:0] length_command;
    logic signed [15:0] setpoint_angle;
    logic [1:0]         waypoint_phase;
    logic [7:0]         steps_left;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_sample;
    logic     wp_update;
    logic     div_start;
    div_sel_t div_sel;
    logic     count_load;
    logic     delta_load;
    logic     sp_update;
    logic     mul_load;
    logic     out_load;
  } rspc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic wp_fire;
    logic div_done;
    logic count_zero;
  } rspc_stat_t;

endpackage

/* src/rspc_if.sv */
// ---------------------------------------------------------------------------
// rspc_if
// Valid/ready channels of the ramped setpoint controller.
// ---------------------------------------------------------------------------

// Sample channel
interface rspc_sample_if import rspc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Result channel
interface rspc_result_if import rspc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Configuration write channel
interface rspc_cfg_if import rspc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  cfg_index_t            index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* src/rspc_div.sv */
// ---------------------------------------------------------------------------
// rspc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "ramped_setpoint_p_controller_unit_assert.svh"

module rspc_div import rspc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [7:0]       divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [7:0]           rem;
  logic [7:0]           dsr;
  logic [DIV_W-1:0]     quo;
  logic [9:0]           trial;

  // Trial subtraction of the divisor from the shifted remainder
  assign trial = {1'b0, rem, quo[DIV_W-1]} - {2'b00, dsr};

  // Sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == DIV_CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dsr <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (!trial[9]) begin
        rem <= trial[7:0];
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= {rem[6:0], quo[DIV_W-1]};
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

  `RSPC_ASSERT_IMP(a_done_after_busy, clk, rst, done, $past(busy), "divider done without work")
  `RSPC_ASSERT_IMP(a_no_start_busy, clk, rst, start, !busy, "divider restarted while busy")

endmodule

/* src/rspc_datapath.sv */
// ---------------------------------------------------------------------------
// rspc_datapath
// Timers, setpoint ramp, step-delta division and gain multiply.
// ---------------------------------------------------------------------------
`include "ramped_setpoint_p_controller_unit_assert.svh"

module rspc_datapath import rspc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  rspc_cmd_t             cmd,
  output rspc_stat_t            stat,
  input  sample_t               sample_data,
  input  logic                  cfg_we,
  input  cfg_index_t            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output result_t               result_data
);

  // Configuration registers
  logic [15:0] waypoint_period;
  logic [7:0]  setpoint_period;
  logic [17:0] drive_gain;
  logic [14:0] step_angle;

  // Controller state
  logic [15:0]        wp_timer;
  logic [7:0]         sp_timer;
  logic [1:0]         phase;
  logic signed [15:0] target;
  logic signed [31:0] accum;
  logic signed [31:0] delta;
  logic [7:0]         remaining;
  logic [7:0]         count;
  logic signed [15:0] measured;
  logic signed [31:0] latched;
  logic signed [31:0] prod_hi;

  // Combinational terms
  logic [15:0]        wp_inc;
  logic               wp_fire;
  logic [7:0]         sp_inc;
  logic               sp_fire;
  logic [DIV_W-1:0]   div_dividend;
  logic [7:0]         div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   quotient;
  logic [7:0]         count_sat;
  logic signed [16:0] diff;
  logic [16:0]        diff_mag;
  logic [31:0]        quo_ext;
  logic signed [32:0] acc_sum;
  logic signed [31:0] acc_sat;
  logic signed [32:0] err;
  logic signed [51:0] product;
  logic signed [32:0] len_full;
  logic signed [31:0] len_sat;
  logic signed [15:0] sp_sat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_period <= WAYPOINT_PERIOD_RST;
      setpoint_period <= SETPOINT_PERIOD_RST;
      drive_gain      <= DRIVE_GAIN_RST;
      step_angle      <= STEP_ANGLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAYPOINT_PERIOD: waypoint_period <= cfg_data[15:0];
        CFG_SETPOINT_PERIOD: setpoint_period <= cfg_data[7:0];
        CFG_DRIVE_GAIN:      drive_gain      <= cfg_data;
        CFG_STEP_ANGLE:      step_angle      <= cfg_data[14:0];
      endcase
    end
  end

  // Timer increments, saturating
  assign wp_inc  = (wp_timer != 16'hFFFF) ? wp_timer + 16'd1 : wp_timer;
  assign wp_fire = (wp_inc >= waypoint_period);
  assign sp_inc  = (sp_timer != 8'hFF) ? sp_timer + 8'd1 : sp_timer;
  assign sp_fire = (sp_inc >= setpoint_period);

  // Distance to target and its magnitude
  assign diff     = {target[15], target} - {measured[15], measured};
  assign diff_mag = diff[16] ? -diff : diff;

  // Step count saturates at the maximum step count
  assign count_sat = (|quotient[DIV_W-1:8]) ? MAX_STEPS : quotient[7:0];
  assign quo_ext   = {{(32 - DIV_W){1'b0}}, quotient};

  // Divider operand selection
  always_comb begin
    unique case (cmd.div_sel)
      DIV_COUNT: begin
        div_dividend = {{(DIV_W - 16){1'b0}}, waypoint_period};
        div_divisor  = setpoint_period;
      end
      DIV_DELTA: begin
        div_dividend = {diff_mag[15:0], {ACC_EXTRA{1'b0}}};
        div_divisor  = count_sat;
      end
    endcase
  end

  rspc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  assign stat.wp_fire    = wp_fire;
  assign stat.div_done   = div_done;
  assign stat.count_zero = (count_sat == 8'd0);

  // Saturating accumulator step
  assign acc_sum = {accum[31], accum} + {delta[31], delta};
  assign acc_sat = (acc_sum[32] != acc_sum[31]) ?
                   (acc_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : acc_sum[31:0];

  // Gain times error, error in accumulator units
  assign err     = {accum[31], accum} - {{9{measured[15]}}, measured, {ACC_EXTRA{1'b0}}};
  assign product = $signed({1'b0, drive_gain}) * err;

  // Length command and setpoint view
  assign len_full = {latched[31], latched} - {prod_hi[31], prod_hi};
  assign len_sat  = (len_full[32] != len_full[31]) ?
                    (len_full[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : len_full[31:0];
  assign sp_sat   = (accum[31:23] == {9{accum[31]}}) ? accum[23:8] :
                    (accum[31] ? 16'sh8000 : 16'sh7FFF);

  // Latch the sample
  always_ff @(posedge clk) begin
    if (rst) begin
      measured <= '0;
      latched  <= '0;
    end else if (cmd.load_sample && sample_data.sample_valid) begin
      measured <= sample_data.sample_theta;
      latched  <= sample_data.sample_length;
    end
  end

  // Waypoint timer, target and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      wp_timer <= '0;
      phase    <= '0;
      target   <= '0;
    end else if (cmd.wp_update) begin
      if (wp_fire) begin
        wp_timer <= '0;
        phase    <= phase + 2'd1;
        if (!phase[1]) begin
          target <= target + $signed({1'b0, step_angle});
        end else begin
          target <= target - $signed({1'b0, step_angle});
        end
      end else begin
        wp_timer <= wp_inc;
      end
    end
  end

  // Step count, delta, setpoint timer and ramp
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      remaining <= '0;
      delta     <= '0;
      accum     <= '0;
      sp_timer  <= '0;
    end else begin
      if (cmd.count_load) begin
        count     <= count_sat;
        remaining <= count_sat;
        if (count_sat == 8'd0) begin
          delta <= '0;
        end
      end
      if (cmd.delta_load) begin
        delta <= diff[16] ? -$signed(quo_ext) : $signed(quo_ext);
      end
      if (cmd.sp_update) begin
        if (sp_fire) begin
          sp_timer <= '0;
          if (remaining != 8'd0) begin
            accum     <= acc_sat;
            remaining <= remaining - 8'd1;
          end
        end else begin
          sp_timer <= sp_inc;
        end
      end
    end
  end

  // Register the scaled product
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_hi <= product[GAIN_SHIFT+31:GAIN_SHIFT];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_data.length_command <= len_sat;
      result_data.setpoint_angle <= sp_sat;
      result_data.waypoint_phase <= phase;
      result_data.steps_left     <= remaining;
    end
  end

  `RSPC_ASSERT_IMP(a_steps_bounded, clk, rst, 1'b1, remaining <= count, "ramp steps exceed count")

endmodule

/* src/rspc_ctrl.sv */
// ---------------------------------------------------------------------------
// rspc_ctrl
// Sequencer for one tick: waypoint, divisions, ramp step, multiply, result.
// ---------------------------------------------------------------------------
`include "ramped_setpoint_p_controller_unit_assert.svh"

module rspc_ctrl import rspc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       res_valid,
  input  logic       res_ready,
  output rspc_cmd_t  cmd,
  input  rspc_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_WAYPT    = 7'b0000010,
    S_CNT_WAIT = 7'b0000100,
    S_DLT_WAIT = 7'b0001000,
    S_STEP     = 7'b0010000,
    S_MUL      = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Hold off sample beats while in reset
  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_COUNT;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_sample = 1'b1;
          state_next      = S_WAYPT;
        end
      end
      S_WAYPT: begin
        cmd.wp_update = 1'b1;
        if (stat.wp_fire) begin
          cmd.div_start = 1'b1;
          state_next    = S_CNT_WAIT;
        end else begin
          state_next = S_STEP;
        end
      end
      S_CNT_WAIT: begin
        if (stat.div_done) begin
          cmd.count_load = 1'b1;
          if (!stat.count_zero) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_DELTA;
            state_next    = S_DLT_WAIT;
          end else begin
            state_next = S_STEP;
          end
        end
      end
      S_DLT_WAIT: begin
        if (stat.div_done) begin
          cmd.delta_load = 1'b1;
          state_next     = S_STEP;
        end
      end
      S_STEP: begin
        cmd.sp_update = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_OUT;
      end
      S_OUT: begin
        if (!res_valid || res_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `RSPC_ASSERT_NXT(a_accept_to_waypt, clk, rst, accept, state == S_WAYPT, "tick not started")
  `RSPC_ASSERT_IMP(a_rise_from_out, clk, rst, $rose(res_valid), $past(state == S_OUT), "result out of sequence")

endmodule

/* src/ramped_setpoint_p_controller_unit.sv */
// ---------------------------------------------------------------------------
// ramped_setpoint_p_controller_unit
// Proportional bend-angle controller with a linearly ramped setpoint.
// ---------------------------------------------------------------------------
// Each accepted sample beat is one millisecond tick and yields exactly one
// result beat. A tick without a waypoint passes through the waypoint, ramp
// step, multiply and output states and is then ready again; a tick on which
// the waypoint timer fires also runs the shared restoring divider twice (step
// count, then per-step delta), or only once when the step count comes out
// zero. The result sits in an output register, so a new tick is taken while
// the last result waits; only the final load stalls until the previous
// result beat has gone. Configuration writes are ready whenever out of reset
// and must only be issued while idle.
module ramped_setpoint_p_controller_unit import rspc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  rspc_sample_if.sink   sample,
  rspc_result_if.source result,
  rspc_cfg_if.sink      cfg
);

  rspc_cmd_t  cmd;
  rspc_stat_t stat;
  logic       in_ready;
  logic       res_valid;
  result_t    result_data;

  assign sample.ready = in_ready;
  assign cfg.ready    = !rst;
  assign result.valid = res_valid;
  assign result.data  = result_data;

  rspc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_ready (result.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  rspc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .sample_data (sample.data),
    .cfg_we      (cfg.valid && cfg.ready),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .result_data (result_data)
  );

endmodule
